FILE: design/cosine_similarity_stream_core_defines.svh
// Assertion macros shared by the cosine similarity stream core.
// No dependencies; each file that asserts includes this header.
`ifndef COSINE_SIMILARITY_STREAM_CORE_DEFINES_SVH
`define COSINE_SIMILARITY_STREAM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("css assertion failed");
`define CSS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("css assertion failed");
`else
`define CSS_ASSERT(lbl, prop)
`define CSS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/css_pkg.sv
// Package for the cosine similarity stream core: widths, states and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package css_pkg;
    localparam int ElemW    = 16;
    localparam int DotW     = 42;
    localparam int NormW    = 41;
    localparam int ProdW    = 2 * NormW;
    localparam int SqW      = 2 * DotW;
    localparam int FracSh   = 28;
    localparam int SearchW  = SqW + FracSh + 1;
    localparam int QW       = 15;
    localparam int KW       = 4;
    localparam int CntW     = 6;
    localparam int SimW     = 16;
    localparam int MulLast  = DotW - 1;
    localparam int KTop     = QW - 1;
    localparam int OneQ14   = 16384;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_SA,
        ST_SB,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic          acc;
        logic          load;
        logic          mul_step;
        logic          srch_a;
        logic          srch_b;
        logic          out_load;
        logic [KW-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic degen_next;
        logic out_free;
    } t_status;
endpackage

FILE: design/css_dp.sv
// Datapath: accumulators, serial shift-add multipliers (dot squared, norm product), bit-by-bit quotient
// search and the output register. Depends on css_pkg.
`timescale 1ns / 1ps
module css_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  css_pkg::t_cmd                       i_cmd,
    output css_pkg::t_status                    o_status,
    input  logic signed [css_pkg::ElemW-1:0]    i_elem_a,
    input  logic signed [css_pkg::ElemW-1:0]    i_elem_b,
    input  logic                                i_last_elem,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic signed [css_pkg::SimW-1:0]     o_similarity,
    output logic                                o_degenerate
);
    localparam int DW  = css_pkg::DotW;
    localparam int NW  = css_pkg::NormW;
    localparam int SW  = css_pkg::SearchW;
    localparam int EW2 = 2 * css_pkg::ElemW;

    logic signed [DW-1:0]             r_dot;
    logic [NW-1:0]                    r_na, r_nb;
    logic [css_pkg::ProdW-1:0]        r_mc_p, r_p;
    logic [NW-1:0]                    r_m_p;
    logic [css_pkg::SqW-1:0]          r_mc_d, r_d;
    logic [DW-1:0]                    r_m_d;
    logic [SW-1:0]                    r_x, r_y, r_t;
    logic [css_pkg::QW-1:0]           r_q;
    logic                             r_neg, r_degen, r_valid;
    logic signed [css_pkg::SimW-1:0]  r_sim;
    logic                             r_deg_out;

    logic signed [EW2-1:0] prod_ab, prod_aa, prod_bb;
    logic signed [DW:0]    dot_sum, dot_next_x, dot_max, dot_min;
    logic [NW:0]           na_sum, nb_sum;
    logic [NW-1:0]         na_next, nb_next;
    logic [DW:0]           mag_x;
    logic [DW-1:0]         mag;
    logic [SW-1:0]         p_ext, r_val, trial;
    logic [css_pkg::KW-1:0] k1;
    logic [css_pkg::KW:0]   k2;
    logic [css_pkg::QW-1:0] q_cap;
    logic [css_pkg::SimW-1:0] q_ext;

    assign prod_ab = i_elem_a * i_elem_b;
    assign prod_aa = i_elem_a * i_elem_a;
    assign prod_bb = i_elem_b * i_elem_b;
    assign dot_max = {2'b00, {(DW-1){1'b1}}};
    assign dot_min = {2'b11, {(DW-1){1'b0}}};
    assign dot_sum = {r_dot[DW-1], r_dot} + (DW+1)'(prod_ab);

    always_comb begin
        if (dot_sum > dot_max) begin
            dot_next_x = dot_max;
        end else if (dot_sum < dot_min) begin
            dot_next_x = dot_min;
        end else begin
            dot_next_x = dot_sum;
        end
    end

    assign na_sum  = {1'b0, r_na} + (NW+1)'(prod_aa[EW2-2:0]);
    assign nb_sum  = {1'b0, r_nb} + (NW+1)'(prod_bb[EW2-2:0]);
    assign na_next = na_sum[NW] ? {NW{1'b1}} : na_sum[NW-1:0];
    assign nb_next = nb_sum[NW] ? {NW{1'b1}} : nb_sum[NW-1:0];
    assign mag_x   = dot_next_x[DW] ? -dot_next_x : dot_next_x;
    assign mag     = mag_x[DW-1:0];

    assign o_status.degen_next = (na_next == '0) || (nb_next == '0);
    assign o_status.out_free   = !r_valid || !i_stall;

    // Trial square (q + 2^k)^2 * P = X + (q*P << (k+1)) + (P << 2k).
    assign p_ext = SW'(r_p);
    assign r_val = {1'b0, r_d, {css_pkg::FracSh{1'b0}}};
    assign k1    = i_cmd.k + css_pkg::KW'(1);
    assign k2    = {i_cmd.k, 1'b0};
    assign trial = r_t + (p_ext << k2);
    assign q_cap = (r_q > css_pkg::QW'(css_pkg::OneQ14)) ? css_pkg::QW'(css_pkg::OneQ14) : r_q;
    assign q_ext = {1'b0, q_cap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot   <= '0;
            r_na    <= '0;
            r_nb    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (i_last_elem) begin
                    r_dot <= '0;
                    r_na  <= '0;
                    r_nb  <= '0;
                end else begin
                    r_dot <= dot_next_x[DW-1:0];
                    r_na  <= na_next;
                    r_nb  <= nb_next;
                end
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mc_p  <= css_pkg::ProdW'(na_next);
            r_m_p   <= nb_next;
            r_p     <= '0;
            r_mc_d  <= css_pkg::SqW'(mag);
            r_m_d   <= mag;
            r_d     <= '0;
            r_neg   <= dot_next_x[DW];
            r_degen <= o_status.degen_next;
            r_x     <= '0;
            r_y     <= '0;
            r_q     <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_m_p[0]) begin
                r_p <= r_p + r_mc_p;
            end
            if (r_m_d[0]) begin
                r_d <= r_d + r_mc_d;
            end
            r_mc_p <= r_mc_p << 1;
            r_m_p  <= r_m_p >> 1;
            r_mc_d <= r_mc_d << 1;
            r_m_d  <= r_m_d >> 1;
        end
        if (i_cmd.srch_a) begin
            r_t <= r_x + (r_y << k1);
        end
        if (i_cmd.srch_b && (trial <= r_val)) begin
            r_x <= trial;
            r_y <= r_y + (p_ext << i_cmd.k);
            r_q <= r_q | (css_pkg::QW'(1) << i_cmd.k);
        end
        if (i_cmd.out_load) begin
            r_deg_out <= r_degen;
            if (r_degen) begin
                r_sim <= '0;
            end else begin
                r_sim <= r_neg ? -$signed(q_ext) : $signed(q_ext);
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_similarity = r_sim;
    assign o_degenerate = r_deg_out;
endmodule

FILE: design/css_ctrl.sv
// Controller: sequences accumulation, serial multiplication, quotient search and
// the output load. Depends on css_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cosine_similarity_stream_core_defines.svh"
module css_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last_elem,
    input  css_pkg::t_status i_status,
    output logic             o_stall,
    output css_pkg::t_cmd    o_cmd
);
    css_pkg::t_state            r_state, n_state;
    logic [css_pkg::CntW-1:0]   r_cnt, n_cnt;
    logic [css_pkg::KW-1:0]     r_k, n_k;
    logic                       accept;

    assign accept = (r_state == css_pkg::ST_ACC) && i_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        unique case (r_state)
            css_pkg::ST_ACC: begin
                if (accept && i_last_elem) begin
                    n_state = i_status.degen_next ? css_pkg::ST_LOAD : css_pkg::ST_MUL;
                    n_cnt   = '0;
                end
            end
            css_pkg::ST_MUL: begin
                n_cnt = r_cnt + css_pkg::CntW'(1);
                if (r_cnt == css_pkg::CntW'(css_pkg::MulLast)) begin
                    n_state = css_pkg::ST_SA;
                    n_k     = css_pkg::KW'(css_pkg::KTop);
                end
            end
            css_pkg::ST_SA: begin
                n_state = css_pkg::ST_SB;
            end
            css_pkg::ST_SB: begin
                if (r_k == '0) begin
                    n_state = css_pkg::ST_LOAD;
                end else begin
                    n_k     = r_k - css_pkg::KW'(1);
                    n_state = css_pkg::ST_SA;
                end
            end
            css_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = css_pkg::ST_ACC;
                end
            end
            default: n_state = css_pkg::ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.k        = r_k;
        o_cmd.acc      = accept;
        o_cmd.load     = accept && i_last_elem;
        o_cmd.mul_step = (r_state == css_pkg::ST_MUL);
        o_cmd.srch_a   = (r_state == css_pkg::ST_SA);
        o_cmd.srch_b   = (r_state == css_pkg::ST_SB);
        o_cmd.out_load = (r_state == css_pkg::ST_LOAD) && i_status.out_free;
        o_stall        = (r_state != css_pkg::ST_ACC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= css_pkg::ST_ACC;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    `CSS_ASSERT(a_sa_then_sb, (r_state == css_pkg::ST_SA) |=> (r_state == css_pkg::ST_SB))
    `CSS_ASSERT(a_sb_after_sa, (r_state == css_pkg::ST_SB) |-> ($past(r_state) == css_pkg::ST_SA))
    `CSS_ASSERT(a_mul_len, (r_state == css_pkg::ST_MUL) && (r_cnt == css_pkg::CntW'(css_pkg::MulLast)) |=> (r_state == css_pkg::ST_SA))
    `CSS_ASSERT(a_k_range, (r_state == css_pkg::ST_SA) |-> (r_k <= css_pkg::KW'(css_pkg::KTop)))
endmodule

FILE: design/cosine_similarity_stream_core.sv
// Accepts one element pair per cycle while accumulating.
// After the last pair the datapath squares the dot product, multiplies the norms and searches
// the quotient bit by bit, then loads the result (squaring and search are skipped when a norm is zero).
// The input stalls until the result has loaded, so the next vector's first pair is taken
// only after that load at the earliest, later while o_valid waits.
// Synchronous active-low reset clears the accumulators and returns to accumulate.
`timescale 1ns / 1ps
module cosine_similarity_stream_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [css_pkg::ElemW-1:0]    i_elem_a,
    input  logic signed [css_pkg::ElemW-1:0]    i_elem_b,
    input  logic                                i_last_elem,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [css_pkg::SimW-1:0]     o_similarity,
    output logic                                o_degenerate
);
    css_pkg::t_cmd    cmd;
    css_pkg::t_status status;

    css_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_elem (i_last_elem),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    css_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_last_elem  (i_last_elem),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_similarity (o_similarity),
        .o_degenerate (o_degenerate)
    );
endmodule

FILE: tb/cosine_similarity_stream_core_tb.sv
// Self-checking testbench for the cosine similarity stream core.
// Drives directed and random element-pair vectors through valid/stall and checks each result
// against a local exact-integer predictor. Depends on css_pkg and the core.
`timescale 1ns / 1ps
module cosine_similarity_stream_core_tb;

    typedef struct packed {
        logic signed [css_pkg::ElemW-1:0] a;
        logic signed [css_pkg::ElemW-1:0] b;
        logic                             last;
    } t_pair;

    typedef struct packed {
        logic signed [css_pkg::SimW-1:0] sim;
        logic                            degen;
    } t_cos;

    localparam int WatchLimit = 20000;
    localparam logic signed [63:0] DotHi = (64'sd1 <<< 41) - 1;
    localparam logic signed [63:0] DotLo = -(64'sd1 <<< 41);
    localparam logic signed [63:0] NormHi = (64'sd1 <<< 41) - 1;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_last_elem, o_valid, i_stall, o_degenerate;
    logic signed [css_pkg::ElemW-1:0] i_elem_a, i_elem_b;
    logic signed [css_pkg::SimW-1:0] o_similarity;

    cosine_similarity_stream_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_elem_a(i_elem_a), .i_elem_b(i_elem_b), .i_last_elem(i_last_elem),
        .o_valid(o_valid), .i_stall(i_stall), .o_similarity(o_similarity),
        .o_degenerate(o_degenerate)
    );

    t_pair pending_pairs[$];
    t_cos  expected_cos[$];
    logic signed [63:0] dot_sum, norm_a_sum, norm_b_sum;
    int  errors = 0;
    int  idle_cycles = 0;
    bit  stim_done = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] clip(logic signed [63:0] v,
            logic signed [63:0] lo, logic signed [63:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Accumulates one pair and, on the last one, computes the expected cosine.
    task automatic predict_cosine(t_pair p);
        logic signed [63:0] ea, eb;
        logic [255:0] rhs, lhs;
        logic [63:0] mag;
        int lo, hi, mid;
        t_cos r;
        ea = p.a;
        eb = p.b;
        dot_sum    = clip(dot_sum + ea * eb, DotLo, DotHi);
        norm_a_sum = clip(norm_a_sum + ea * ea, 0, NormHi);
        norm_b_sum = clip(norm_b_sum + eb * eb, 0, NormHi);
        if (!p.last) return;
        if (norm_a_sum == 0 || norm_b_sum == 0) begin
            r.sim = '0;
            r.degen = 1'b1;
        end else begin
            mag = dot_sum < 0 ? -dot_sum : dot_sum;
            rhs = ({192'd0, mag} * {192'd0, mag}) << 28;
            lo = 0;
            hi = css_pkg::OneQ14;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                lhs = 256'(mid) * 256'(mid) * 256'(norm_a_sum) * 256'(norm_b_sum);
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            r.sim = dot_sum < 0 ? -css_pkg::SimW'(lo) : css_pkg::SimW'(lo);
            r.degen = 1'b0;
        end
        expected_cos.push_back(r);
        dot_sum = 0;
        norm_a_sum = 0;
        norm_b_sum = 0;
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    function automatic logic [css_pkg::ElemW-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return css_pkg::ElemW'($urandom);
        endcase
    endfunction

    task automatic add_vector(int len, bit zero_a, bit zero_b);
        t_pair p;
        for (int i = 0; i < len; i++) begin
            p.a = zero_a ? '0 : rand_elem();
            p.b = zero_b ? '0 : rand_elem();
            p.last = (i == len - 1);
            pending_pairs.push_back(p);
        end
    endtask

    task automatic add_pair(logic [css_pkg::ElemW-1:0] a, logic [css_pkg::ElemW-1:0] b,
            bit last);
        t_pair p;
        p.a = a;
        p.b = b;
        p.last = last;
        pending_pairs.push_back(p);
    endtask

    initial begin
        // Directed: extremes, parallel and opposite, zero norms, one-pair vectors.
        add_pair(16'h7fff, 16'h7fff, 1);
        add_pair(16'h8000, 16'h8000, 1);
        add_pair(16'h8000, 16'h7fff, 1);
        add_pair(16'h0000, 16'h1234, 1);
        add_pair(16'h4321, 16'h0000, 1);
        add_pair(16'h0000, 16'h0000, 1);
        add_pair(16'h0001, 16'hffff, 0);
        add_pair(16'hffff, 16'h0001, 1);
        add_pair(16'h1000, 16'h0000, 0);
        add_pair(16'h0000, 16'h1000, 1);
        add_pair(16'h5555, 16'haaaa, 0);
        add_pair(16'haaaa, 16'h5555, 1);
        // Long enough that the dot product and both norms saturate.
        for (int i = 0; i < 2050; i++) add_pair(16'h8000, 16'h7fff, i == 2049);
        while (pending_pairs.size() < 2300) begin
            case ($urandom_range(0, 9))
                0: add_vector($urandom_range(1, 4), $urandom_range(0, 1), 1'b0);
                1: add_vector($urandom_range(1, 4), 1'b0, 1'b1);
                default: add_vector($urandom_range(1, 30), 1'b0, 1'b0);
            endcase
        end
        stim_done = 1;
    end

    initial begin
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // Driver: presents queued pairs with random gaps, holding while stalled.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_elem_a <= '0;
            i_elem_b <= '0;
            i_last_elem <= 0;
            dot_sum = 0;
            norm_a_sum = 0;
            norm_b_sum = 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_cosine(pending_pairs.pop_front());
                send_gap = gap_len();
            end
            if (!(i_valid && o_stall)) begin
                if (send_gap == 0 && pending_pairs.size() > 0) begin
                    i_valid <= 1;
                    i_elem_a <= pending_pairs[0].a;
                    i_elem_b <= pending_pairs[0].b;
                    i_last_elem <= pending_pairs[0].last;
                end else begin
                    i_valid <= 0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    // Receiver stall: random gaps, plus one long hold-off early in the run.
    int recv_gap = 0;
    int cycle_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            cycle_cnt++;
            if (cycle_cnt == 400) begin
                recv_gap = 600;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1;
            end else begin
                if ($urandom_range(0, 3) == 0) recv_gap = gap_len();
                i_stall <= (recv_gap > 0);
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_cos e;
        if (i_rst_n) begin
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (o_valid && !i_stall) begin
                if (expected_cos.size() == 0) begin
                    $error("unexpected result similarity=%0d", o_similarity);
                    errors++;
                end else begin
                    e = expected_cos.pop_front();
                    if (o_similarity !== e.sim) begin
                        $error("similarity expected %0d actual %0d", e.sim, o_similarity);
                        errors++;
                    end
                    if (o_degenerate !== e.degen) begin
                        $error("degenerate expected %0d actual %0d", e.degen, o_degenerate);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WatchLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (pending_pairs.size() == 0 && !i_valid);
        wait (expected_cos.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_cos.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/css_pkg.sv
design/css_dp.sv
design/css_ctrl.sv
design/cosine_similarity_stream_core.sv
tb/cosine_similarity_stream_core_tb.sv
